[design/cbt_pkg.sv]
// Shared types, constants and weight function of the cubic B-spline tessellator.
`default_nettype none
package cbt_pkg;

  localparam int COORD_W     = 24;
  localparam int STEPS_DEF   = 32;
  localparam int QUEUE_DEPTH = 2;

  // One control point: index 0 is x, 1 is y, 2 is z.
  typedef logic [2:0][COORD_W-1:0] point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      final_point;
  } in_payload_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      run_end;
  } out_payload_t;

  typedef enum logic {
    KIND_PASS,
    KIND_SPAN
  } kind_t;

  // Work for the back end: a span of four points or a short curve passed through.
  typedef struct packed {
    kind_t           kind;
    logic [1:0]      last_idx;
    point_t [3:0]    pts;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Integer blending weight k of sample j for s steps; the four sum to 6*s^3.
  function automatic int bspl_weight(int k, int j, int s);
    int u;
    u = s - j;
    case (k)
      0:       return u * u * u;
      1:       return 3 * j * j * j - 6 * j * j * s + 4 * s * s * s;
      2:       return -3 * j * j * j + 3 * j * j * s + 3 * j * s * s + s * s * s;
      default: return j * j * j;
    endcase
  endfunction

endpackage
`default_nettype wire

[design/cbt_queue.sv]
// Short work queue between the front end and the sample generator.
`default_nettype none
module cbt_queue #(
  parameter int QDEPTH = cbt_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire cbt_pkg::q_entry_t push_data,
  input  wire logic              pop,
  output cbt_pkg::q_entry_t      head,
  output cbt_pkg::q_status_t     status
);

  localparam int PTRW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNTW = $clog2(QDEPTH + 1);

  cbt_pkg::q_entry_t mem_r [QDEPTH];
  logic [PTRW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTRW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTRW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign head         = mem_r[rd_ptr_r];
  assign status.full  = (cnt_r == CNTW'(QDEPTH));
  assign status.empty = (cnt_r == '0);

endmodule
`default_nettype wire

[design/cbt_front.sv]
// Front end: accepts control points, keeps the window and queues span or pass work.
`default_nettype none
module cbt_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire cbt_pkg::in_payload_t in_data,
  input  wire cbt_pkg::q_status_t   q_status,
  output logic                      push,
  output cbt_pkg::q_entry_t         push_data
);

  cbt_pkg::point_t win_r [3];
  logic [1:0]      held_r;
  cbt_pkg::point_t cur;
  logic            accept;
  logic            full_win;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign full_win = (held_r == 2'd3);

  always_comb begin
    cur[0] = in_data.x;
    cur[1] = in_data.y;
    cur[2] = in_data.z;
  end

  always_comb begin
    push_data.kind     = full_win ? cbt_pkg::KIND_SPAN : cbt_pkg::KIND_PASS;
    push_data.last_idx = held_r;
    for (int i = 0; i < 3; i++) begin
      // A short curve lists its held points and then the current one.
      push_data.pts[i] = (full_win || (2'(i) < held_r)) ? win_r[i] : cur;
    end
    push_data.pts[3] = cur;
  end

  assign push = accept && (in_data.final_point || full_win);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (accept) begin
      if (!full_win && !in_data.final_point) begin
        win_r[held_r] <= cur;
        held_r        <= held_r + 2'd1;
      end else if (in_data.final_point) begin
        held_r <= '0;
      end else begin
        win_r[0] <= win_r[1];
        win_r[1] <= win_r[2];
        win_r[2] <= cur;
      end
    end
  end

endmodule
`default_nettype wire

[design/cbt_back.sv]
// Back end: issues samples, blends with multipliers and divides by reciprocal multiplication.
`default_nettype none
module cbt_back #(
  parameter int STEPS = cbt_pkg::STEPS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cbt_pkg::q_entry_t head,
  input  wire cbt_pkg::q_status_t q_status,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output cbt_pkg::out_payload_t  out_data
);

  localparam int CW_COORD = cbt_pkg::COORD_W;
  localparam int DEN  = 6 * STEPS * STEPS * STEPS;
  localparam int HALF = 3 * STEPS * STEPS * STEPS;
  localparam int DW   = $clog2(DEN + 1);
  localparam int PW   = CW_COORD + DW + 1;
  localparam int AW   = PW + 2;
  localparam int NW   = CW_COORD + DW;
  localparam int QW   = CW_COORD;
  localparam int JW   = (STEPS > 1) ? $clog2(STEPS + 1) : 1;
  localparam int CW   = (JW > 2) ? JW : 2;

  // Reciprocal estimate: the upper NHW bits of the dividend times floor(2^NW / DEN).
  localparam int TW   = DW - 1;
  localparam int NHW  = NW - TW;
  localparam int MW   = NHW + 1;
  localparam int RW   = NHW + MW;
  localparam longint MREC = (longint'(1) << NW) / longint'(DEN);
  localparam logic [MW-1:0] MREC_V = MW'(MREC);
  localparam logic [NW-1:0] DEN_N  = NW'(DEN);
  localparam logic [NW-1:0] DEN2_N = NW'(2 * DEN);

  // Constant weight table, one row per weight and one entry per sample.
  logic [DW-1:0] wtab [4][STEPS+1];
  for (genvar k = 0; k < 4; k++) begin : g_wk
    for (genvar j = 0; j <= STEPS; j++) begin : g_wj
      assign wtab[k][j] = DW'(cbt_pkg::bspl_weight(k, j, STEPS));
    end
  end

  logic adv;
  logic head_valid;
  logic issue;
  logic last_sel;
  logic [CW-1:0] cnt_r;

  assign adv        = !out_valid || out_ready;
  assign head_valid = !q_status.empty;
  assign issue      = adv && head_valid;

  always_comb begin
    if (head.kind == cbt_pkg::KIND_PASS) begin
      last_sel = (cnt_r[1:0] == head.last_idx);
    end else begin
      last_sel = (cnt_r == CW'(STEPS));
    end
  end

  assign pop = issue && last_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (issue) begin
      cnt_r <= last_sel ? '0 : cnt_r + 1'b1;
    end
  end

  // Stage 1: operands.
  cbt_pkg::point_t s1_p_nxt [4];
  logic [DW-1:0]   s1_w_nxt [4];
  cbt_pkg::point_t s1_p_r   [4];
  logic [DW-1:0]   s1_w_r   [4];
  logic            s1_v_r, s1_last_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      s1_p_nxt[k] = head.pts[k];
      s1_w_nxt[k] = wtab[k][cnt_r[JW-1:0]];
    end
    if (head.kind == cbt_pkg::KIND_PASS) begin
      // A passed point goes through with full weight, which divides back exactly.
      s1_p_nxt[0] = head.pts[cnt_r[1:0]];
      s1_w_nxt[0] = DW'(DEN);
      for (int k = 1; k < 4; k++) begin
        s1_w_nxt[k] = '0;
      end
    end
  end

  // Stage 2: products. Stage 3: sums.
  logic signed [PW-1:0] s2_prod_r [3][4];
  logic                 s2_v_r, s2_last_r;
  logic signed [AW-1:0] s3_acc_r  [3];
  logic                 s3_v_r, s3_last_r;

  // Division: the rounded dividend N = |acc| + DEN/2 gets a reciprocal estimate from its
  // upper bits, which is never high and at most two low, then the estimate times DEN,
  // then a correction from the remainder.
  logic [NW-1:0]  dv_n_r   [3];
  logic [2:0]     dv_neg_r;
  logic           dv_v_r, dv_last_r;
  logic [NW-1:0]  da_n_r   [3];
  logic [QW-1:0]  da_q_r   [3];
  logic [2:0]     da_neg_r;
  logic           da_v_r, da_last_r;
  logic [NW-1:0]  db_n_r   [3];
  logic [NW-1:0]  db_qd_r  [3];
  logic [QW-1:0]  db_q_r   [3];
  logic [2:0]     db_neg_r;
  logic           db_v_r, db_last_r;
  logic [QW-1:0]  dc_q_r   [3];
  logic [2:0]     dc_neg_r;
  logic           dc_v_r, dc_last_r;

  logic [AW-1:0]  mag  [3];
  logic [RW-1:0]  est  [3];
  logic [NW-1:0]  rem  [3];
  logic [QW-1:0]  qfix [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mag[c] = s3_acc_r[c][AW-1] ? AW'(-s3_acc_r[c]) : AW'(s3_acc_r[c]);
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      est[c]  = RW'(dv_n_r[c][NW-1:TW]) * RW'(MREC_V);
      rem[c]  = db_n_r[c] - db_qd_r[c];
      qfix[c] = db_q_r[c];
      if (rem[c] >= DEN2_N) begin
        qfix[c] = db_q_r[c] + QW'(2);
      end else if (rem[c] >= DEN_N) begin
        qfix[c] = db_q_r[c] + QW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        s1_p_r[k] <= s1_p_nxt[k];
        s1_w_r[k] <= s1_w_nxt[k];
      end
      s1_last_r <= last_sel;
      for (int c = 0; c < 3; c++) begin
        for (int k = 0; k < 4; k++) begin
          s2_prod_r[c][k] <= $signed(s1_p_r[k][c]) * $signed({1'b0, s1_w_r[k]});
        end
      end
      s2_last_r <= s1_last_r;
      for (int c = 0; c < 3; c++) begin
        s3_acc_r[c] <= AW'(s2_prod_r[c][0]) + AW'(s2_prod_r[c][1])
                     + AW'(s2_prod_r[c][2]) + AW'(s2_prod_r[c][3]);
      end
      s3_last_r <= s2_last_r;
      for (int c = 0; c < 3; c++) begin
        dv_n_r[c]   <= NW'(mag[c]) + NW'(HALF);
        dv_neg_r[c] <= s3_acc_r[c][AW-1];
        da_n_r[c]   <= dv_n_r[c];
        da_q_r[c]   <= est[c][NHW +: QW];
        db_n_r[c]   <= da_n_r[c];
        db_q_r[c]   <= da_q_r[c];
        db_qd_r[c]  <= NW'(da_q_r[c]) * DEN_N;
        dc_q_r[c]   <= qfix[c];
      end
      dv_last_r <= s3_last_r;
      da_neg_r  <= dv_neg_r;
      da_last_r <= dv_last_r;
      db_neg_r  <= da_neg_r;
      db_last_r <= da_last_r;
      dc_neg_r  <= db_neg_r;
      dc_last_r <= db_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      dv_v_r <= 1'b0;
      da_v_r <= 1'b0;
      db_v_r <= 1'b0;
      dc_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= head_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      dv_v_r <= s3_v_r;
      da_v_r <= dv_v_r;
      db_v_r <= da_v_r;
      dc_v_r <= db_v_r;
    end
  end

  // Output register: apply the sign to each quotient.
  logic [QW-1:0] res [3];
  logic          out_valid_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      res[c] = dc_neg_r[c] ? QW'(-dc_q_r[c]) : dc_q_r[c];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.out_x   <= $signed(res[0]);
      out_data.out_y   <= $signed(res[1]);
      out_data.out_z   <= $signed(res[2]);
      out_data.run_end <= dc_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dc_v_r;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_pop_needs_work : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (head_valid && adv))
    else $error("queue popped without an issued sample");

  a_pass_index : assert property (@(posedge clk) disable iff (!rst_n)
    (head_valid && head.kind == cbt_pkg::KIND_PASS) |-> (cnt_r <= CW'(head.last_idx)))
    else $error("pass-through index ran past the curve's points");

  a_span_index : assert property (@(posedge clk) disable iff (!rst_n)
    (head_valid && head.kind == cbt_pkg::KIND_SPAN) |-> (cnt_r <= CW'(STEPS)))
    else $error("sample counter ran past the last sample");

  a_stall_holds_pipe : assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(dc_v_r) && $stable(s1_v_r)))
    else $error("pipeline moved while the output was stalled");
`endif

endmodule
`default_nettype wire

[design/cubic_bspline_tessellator_unit.sv]
// Uniform cubic B-spline tessellator: control points in, STEPS+1 curve samples per span out.
// Throughput: the sample issue counter in the back end starts one sample per cycle while
// the output does not stall and the queue is not empty. A point that completes a span gives
// STEPS+1 samples, a filling point gives none and a short curve of n points gives n samples.
// Each sample passes the operand, multiply, sum, round, three divide and output registers.
// Reset is synchronous and active low; it empties the queue and all pipeline valid bits.
`default_nettype none
module cubic_bspline_tessellator_unit #(
  parameter int STEPS  = cbt_pkg::STEPS_DEF,
  parameter int QDEPTH = cbt_pkg::QUEUE_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire cbt_pkg::in_payload_t  in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output cbt_pkg::out_payload_t      out_data
);

  // The front end owns the three-point window. A transfer that closes a span, or that
  // ends a curve, becomes one queue entry; other points are only stored in the window.
  cbt_pkg::q_entry_t  push_data;
  cbt_pkg::q_entry_t  head;
  cbt_pkg::q_status_t q_status;
  logic               push;
  logic               pop;

  cbt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  // The queue lets the front take the next points while the back is still sampling a span.
  cbt_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  // The back end blends each sample exactly with integer weights and divides by 6*STEPS^3,
  // rounding half away from zero. Its whole pipeline stalls together when the output
  // register holds a sample that has not been taken.
  cbt_back #(
    .STEPS (STEPS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
